[rtl/pwlb_pkg.sv]
// Package for the pixel word layer blend pipeline.
// Holds register indexes, format and mode codes and the luma coefficients.
// No dependencies.
package pwlb_pkg;

  typedef enum logic [1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_BLEND_MODE   = 2'd1,
    CFG_LEVEL        = 2'd2,
    CFG_CHROMA_EN    = 2'd3
  } cfg_index_t;

  typedef enum logic {
    FMT_YUY2  = 1'b0,
    FMT_RGB32 = 1'b1
  } pixel_format_t;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_SUB  = 2'd1,
    MODE_FAST = 2'd2,
    MODE_NONE = 2'd3
  } blend_mode_t;

  localparam logic [8:0]  LEVEL_MAX    = 9'd256;
  localparam logic [8:0]  LEVEL_RESET  = 9'd255;
  localparam logic [7:0]  NULL_CHROMA  = 8'd128;
  localparam logic [14:0] LUMA_C0      = 15'd9798;
  localparam logic [14:0] LUMA_C1      = 15'd19235;
  localparam logic [14:0] LUMA_C2      = 15'd3736;
  localparam logic [31:0] FAST_SHIFT_MASK = 32'h7f7f7f7f;
  localparam logic [31:0] FAST_LSB_MASK   = 32'h01010101;

endpackage

[rtl/pwlb_lerp_lane.sv]
// One byte lane of the blend: registered (ov - base) * k, then base + product[15:8].
// Depends on nothing beyond the clock; stage enable comes from the top level.
module pwlb_lerp_lane (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] base_byte,
  input  logic [7:0] ov_byte,
  input  logic [8:0] k,
  output logic [7:0] result_byte
);

  logic signed [8:0]  diff;
  logic signed [9:0]  k_s;
  logic signed [18:0] prod;
  logic [7:0]         base_q;
  logic [7:0]         step_q;

  assign diff = $signed({1'b0, ov_byte}) - $signed({1'b0, base_byte});
  assign k_s  = $signed({1'b0, k});
  assign prod = diff * k_s;

  always_ff @(posedge clk) begin
    if (en) begin
      base_q <= base_byte;
      step_q <= prod[15:8];
    end
  end

  assign result_byte = base_q + step_q;

endmodule

[rtl/pixel_word_layer_blend.sv]
// Top level of the pixel word layer blend: config registers and a four stage pipeline.
// Depends on pwlb_pkg and pwlb_lerp_lane.
//
// Usage:
//   s_tdata carries one request: base_word in [31:0], overlay_word in [63:32].
//   m_tdata returns result_word, m_tuser[0] returns mode_error.
//   Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// Pipeline: four register stages; a request taken into stage 1 moves on through stages
//   2 and 3 into stage 4, whose valid bit drives m_tvalid.
// Throughput: one word per clock when not stalled; each stage holds one word and has
//   its own valid bit, so bubbles close up and s_tready stays high while any stage is free.
// Stages: 1 overlay inversion, alpha * level and the three luma products;
//   2 luma sum, weight and overlay byte selection; 3 four byte multiplies;
//   4 add back onto the base, fast average and output select.
// Reset: rst clears all valid bits and loads the register defaults
//   (YUY2, add mode, level 255, full chroma).
// Stall: when m_tready is low the output holds; upstream stages keep filling
//   until all four are full, then s_tready drops. Nothing is lost or repeated.
module pixel_word_layer_blend
  import pwlb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // base_word [31:0], overlay_word [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_word [31:0]
  output logic [0:0]  m_tuser,   // mode_error [0]
  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  logic [8:0]  cfg_data
);

  pixel_format_t pixel_format;
  blend_mode_t   blend_mode;
  logic [8:0]    level;
  logic          chroma_en;
  logic [8:0]    lev;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_YUY2;
      blend_mode   <= MODE_ADD;
      level        <= LEVEL_RESET;
      chroma_en    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_FORMAT: pixel_format <= pixel_format_t'(cfg_data[0]);
        CFG_BLEND_MODE:   blend_mode   <= blend_mode_t'(cfg_data[1:0]);
        CFG_LEVEL:        level        <= cfg_data;
        CFG_CHROMA_EN:    chroma_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign lev = (level > LEVEL_MAX) ? LEVEL_MAX : level;

  // stage handshake
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4      = !v4 || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1
  logic [31:0] in_base, in_ov, in_ovx;
  logic [31:0] base1, ov1, ovx1;
  logic [15:0] kprod1;
  logic [22:0] luma0_1, luma1_1, luma2_1;

  assign in_base = s_tdata[31:0];
  assign in_ov   = s_tdata[63:32];
  assign in_ovx  = (blend_mode == MODE_SUB) ? ~in_ov : in_ov;

  always_ff @(posedge clk) begin
    if (en1) begin
      base1   <= in_base;
      ov1     <= in_ov;
      ovx1    <= in_ovx;
      kprod1  <= 16'(in_ov[31:24] * lev);
      luma0_1 <= 23'(in_ovx[7:0] * LUMA_C0);
      luma1_1 <= 23'(in_ovx[15:8] * LUMA_C1);
      luma2_1 <= 23'(in_ovx[23:16] * LUMA_C2);
    end
  end

  // stage 2
  logic [23:0] luma_sum;
  logic [7:0]  luma_y;
  logic [31:0] ob_sel;
  logic [8:0]  k_sel;
  logic [31:0] base2, ov2, ob2;
  logic [8:0]  k2;

  assign luma_sum = {1'b0, luma0_1} + {1'b0, luma1_1} + {1'b0, luma2_1};
  assign luma_y   = luma_sum[22:15];

  always_comb begin
    ob_sel = ovx1;
    k_sel  = lev;
    if (pixel_format == FMT_RGB32) begin
      k_sel = {1'b0, kprod1[15:8]};
      if (!chroma_en) ob_sel = {4{luma_y}};
    end else if (!chroma_en) begin
      ob_sel = {NULL_CHROMA, ovx1[23:16], NULL_CHROMA, ovx1[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      base2 <= base1;
      ov2   <= ov1;
      ob2   <= ob_sel;
      k2    <= k_sel;
    end
  end

  // stage 3: lanes register the products
  logic [31:0] base3, ov3, lerp3;

  always_ff @(posedge clk) begin
    if (en3) begin
      base3 <= base2;
      ov3   <= ov2;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    pwlb_lerp_lane u_lane (
      .clk         (clk),
      .en          (en3),
      .base_byte   (base2[8*i +: 8]),
      .ov_byte     (ob2[8*i +: 8]),
      .k           (k2),
      .result_byte (lerp3[8*i +: 8])
    );
  end

  // stage 4: output register
  logic [31:0] fast3, res_sel;
  logic        err_sel;
  logic [31:0] res4;
  logic        err4;

  assign fast3 = ((base3 >> 1) & FAST_SHIFT_MASK) + ((ov3 >> 1) & FAST_SHIFT_MASK)
               + (base3 & FAST_LSB_MASK);

  always_comb begin
    res_sel = base3;
    err_sel = 1'b0;
    case (blend_mode)
      MODE_ADD, MODE_SUB: res_sel = lerp3;
      MODE_FAST: begin
        if (chroma_en) res_sel = fast3;
        else           err_sel = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      res4 <= res_sel;
      err4 <= err_sel;
    end
  end

  assign m_tvalid   = v4;
  assign m_tdata    = res4;
  assign m_tuser[0] = err4;

endmodule

[rtl/pwlb_checker.sv]
// Port-level checker for pixel_word_layer_blend, attached by the bind below.
// Watches the stream handshakes and the held output payload; no package dependency.
module pwlb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // backpressure reaches the input only when the output is full and stalled
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("s_tready low without a stalled output");

  // with no requests and the receiver ready, every stage empties and m_tvalid drops
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!s_tvalid && m_tready) ##1 (!s_tvalid && m_tready) ##1
    (!s_tvalid && m_tready) ##1 (!s_tvalid && m_tready) |=> !m_tvalid)
    else $error("result appeared without a request");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
    else $error("output payload changed while stalled");

endmodule

bind pixel_word_layer_blend pwlb_checker u_pwlb_checker (.*);

[test/tb_top.sv]
// Self-checking testbench for pixel_word_layer_blend: directed corners, then random blends.
// Predicts every result word and error flag from its own copy of the registers.
// Depends on pwlb_pkg and the pixel_word_layer_blend RTL.
`timescale 1ns / 100ps

module tb_top;
  import pwlb_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic        err;
  } blend_out_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // base_word [31:0], overlay_word [63:32]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // result_word [31:0]
  logic [0:0]  m_tuser;   // mode_error [0]
  logic        cfg_we;
  cfg_index_t  cfg_index;
  logic [8:0]  cfg_data;

  pixel_word_layer_blend dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the blend registers
  pixel_format_t cur_format = FMT_YUY2;
  blend_mode_t   cur_mode   = MODE_ADD;
  logic [8:0]    cur_level  = LEVEL_RESET;
  logic          cur_chroma = 1'b1;

  blend_out_t pending_blends[$];
  int         requests_sent = 0;
  int         results_checked = 0;
  int         errors_seen = 0;
  int         fail_count = 0;
  int         setting_count = 0;
  bit         sender_idles = 1'b1;
  bit         receiver_idles = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("%0t: timeout with %0d results outstanding", $time, pending_blends.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] lerp_byte(input logic [7:0] b, input logic [7:0] o,
                                           input logic [8:0] k);
    logic [31:0] diff;
    logic [31:0] prod;
    diff = {24'd0, o} - {24'd0, b};
    prod = diff * {23'd0, k};
    return b + prod[15:8];
  endfunction

  function automatic blend_out_t blend_word(input logic [31:0] base, input logic [31:0] ov);
    blend_out_t  r;
    logic [8:0]  lev;
    logic [8:0]  k;
    logic [16:0] alpha_prod;
    logic [31:0] ovx;
    logic [23:0] luma_sum;
    logic [7:0]  ob [4];
    lev = (cur_level > LEVEL_MAX) ? LEVEL_MAX : cur_level;
    r.word = base;
    r.err = 1'b0;
    case (cur_mode)
      MODE_FAST: begin
        if (cur_chroma)
          r.word = ((base >> 1) & FAST_SHIFT_MASK) + ((ov >> 1) & FAST_SHIFT_MASK)
                 + (base & FAST_LSB_MASK);
        else
          r.err = 1'b1;
      end
      MODE_ADD, MODE_SUB: begin
        ovx = (cur_mode == MODE_SUB) ? ~ov : ov;
        for (int i = 0; i < 4; i++) ob[i] = ovx[8*i +: 8];
        if (cur_format == FMT_RGB32) begin
          // weight always from the untouched overlay alpha
          alpha_prod = ov[31:24] * lev;
          k = {1'b0, alpha_prod[15:8]};
          if (!cur_chroma) begin
            luma_sum = ovx[7:0] * LUMA_C0 + ovx[15:8] * LUMA_C1 + ovx[23:16] * LUMA_C2;
            for (int i = 0; i < 4; i++) ob[i] = luma_sum[22:15];
          end
        end else begin
          k = lev;
          if (!cur_chroma) begin
            ob[1] = NULL_CHROMA;
            ob[3] = NULL_CHROMA;
          end
        end
        for (int i = 0; i < 4; i++) r.word[8*i +: 8] = lerp_byte(base[8*i +: 8], ob[i], k);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [7:0]  corners [6];
    corners = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
    w = $urandom;
    for (int i = 0; i < 4; i++)
      if ($urandom_range(0, 3) == 0) w[8*i +: 8] = corners[$urandom_range(0, 5)];
    return w;
  endfunction

  task automatic send_pixels(input logic [31:0] base, input logic [31:0] ov);
    int gap;
    gap = sender_idles ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ov, base};
    do @(posedge clk); while (!s_tready);
    pending_blends.push_back(blend_word(base, ov));
    requests_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending_blends.size() == 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [8:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_PIXEL_FORMAT: cur_format = pixel_format_t'(val[0]);
      CFG_BLEND_MODE:   cur_mode   = blend_mode_t'(val[1:0]);
      CFG_LEVEL:        cur_level  = val;
      CFG_CHROMA_EN:    cur_chroma = val[0];
      default: ;
    endcase
  endtask

  task automatic set_blend(input pixel_format_t fmt, input blend_mode_t mode,
                           input logic [8:0] lev, input logic chroma);
    wait_idle();
    // upper bits of the narrow registers carry junk; only the low bits count
    write_reg(CFG_PIXEL_FORMAT, {8'($urandom), fmt});
    write_reg(CFG_BLEND_MODE, {7'($urandom), mode});
    write_reg(CFG_LEVEL, lev);
    write_reg(CFG_CHROMA_EN, {8'($urandom), chroma});
    setting_count++;
  endtask

  // receiver side: random stalls per result
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = receiver_idles ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    blend_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_blends.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result word %h error %b", $time, m_tdata, m_tuser[0]);
      end else begin
        want = pending_blends.pop_front();
        results_checked++;
        if (want.err) errors_seen++;
        if (m_tdata !== want.word) begin
          fail_count++;
          $display("%0t: result_word expected %h actual %h", $time, want.word, m_tdata);
        end
        if (m_tuser[0] !== want.err) begin
          fail_count++;
          $display("%0t: mode_error expected %b actual %b", $time, want.err, m_tuser[0]);
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_pixels(32'h0000_0000, 32'hffff_ffff);
    send_pixels(32'hffff_ffff, 32'h0000_0000);
    send_pixels(32'ha5a5_a5a5, 32'h5a5a_5a5a);
  endtask

  task automatic test_level_saturation();
    set_blend(FMT_YUY2, MODE_ADD, 9'd0, 1'b1);
    send_pixels(32'h1234_5678, 32'hfedc_ba98);
    set_blend(FMT_YUY2, MODE_ADD, LEVEL_MAX, 1'b1);
    send_pixels(32'h1234_5678, 32'hfedc_ba98);
    set_blend(FMT_YUY2, MODE_ADD, 9'h1ff, 1'b1);
    send_pixels(32'h00ff_00ff, 32'hff00_ff00);
  endtask

  task automatic test_rgb32_alpha();
    set_blend(FMT_RGB32, MODE_ADD, LEVEL_MAX, 1'b1);
    send_pixels(32'h00ab_cdef, 32'hff12_3456);
    send_pixels(32'h00ab_cdef, 32'h0012_3456);
    set_blend(FMT_RGB32, MODE_ADD, 9'd257, 1'b1);
    send_pixels(32'hff00_7f80, 32'h80ff_0001);
    set_blend(FMT_RGB32, MODE_SUB, 9'd200, 1'b1);
    send_pixels(32'h4080_c0ff, 32'hc000_ff7f);
  endtask

  task automatic test_luma_and_null_chroma();
    set_blend(FMT_YUY2, MODE_ADD, 9'd255, 1'b0);
    send_pixels(32'h1020_3040, 32'hffff_ffff);
    set_blend(FMT_YUY2, MODE_SUB, 9'd128, 1'b0);
    send_pixels(32'hff00_ff00, 32'h0000_0000);
    set_blend(FMT_RGB32, MODE_ADD, LEVEL_MAX, 1'b0);
    send_pixels(32'h0000_0000, 32'hffff_ffff);
    set_blend(FMT_RGB32, MODE_SUB, LEVEL_MAX, 1'b0);
    send_pixels(32'h8080_8080, 32'h0010_2030);
  endtask

  task automatic test_fast_and_undefined();
    set_blend(FMT_YUY2, MODE_FAST, 9'd0, 1'b1);
    send_pixels(32'hffff_ffff, 32'hffff_ffff);
    set_blend(FMT_RGB32, MODE_FAST, 9'h1ff, 1'b1);
    send_pixels(32'h0101_0101, 32'h0000_0000);
    set_blend(FMT_RGB32, MODE_FAST, 9'd255, 1'b0);
    send_pixels(32'hdead_beef, 32'h1234_5678);
    set_blend(FMT_YUY2, MODE_NONE, 9'd100, 1'b1);
    send_pixels(32'hcafe_f00d, 32'h0bad_cafe);
  endtask

  task automatic test_random_blends();
    int          run_len;
    logic [8:0]  lev;
    while (requests_sent < 1950) begin
      case ($urandom_range(0, 7))
        0: lev = 9'd0;
        1: lev = 9'd1;
        2: lev = 9'd255;
        3: lev = LEVEL_MAX;
        4: lev = 9'd257;
        5: lev = 9'h1ff;
        default: lev = 9'($urandom_range(0, 511));
      endcase
      set_blend(pixel_format_t'($urandom_range(0, 1)), blend_mode_t'($urandom_range(0, 3)),
                lev, 1'($urandom_range(0, 1)));
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      run_len = $urandom_range(10, 90);
      for (int i = 0; i < run_len; i++) begin
        send_pixels(random_word(), random_word());
        if ($urandom_range(0, 127) == 0) wait_idle();
      end
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_PIXEL_FORMAT;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_level_saturation();
    test_rgb32_alpha();
    test_luma_and_null_chroma();
    test_fast_and_undefined();
    test_random_blends();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Blended %0d requests over %0d register settings, both formats and all modes;",
             requests_sent, setting_count);
    $display("%0d results checked, %0d of them flagged as mode errors.",
             results_checked, errors_seen);
    if (fail_count == 0 && pending_blends.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
